@@ hw/rtl/pio_pkg.sv @@
// Shared types and constants for the periodic image overlap finder.
package pio_pkg;

   localparam int LEN_BITS       = 23;
   localparam int SHIFT_BITS     = 24;
   localparam int NUM_AXES       = 3;
   localparam int NUM_OFS        = 3;
   localparam int NUM_IMAGES     = NUM_OFS * NUM_OFS * NUM_OFS;
   localparam int CENTER_IMAGE   = (NUM_IMAGES - 1) / 2;
   localparam int CSR_INDEX_BITS = 2;

   // offset codes along one axis, also the bit position in an axis_hit_type
   localparam int OFS_NEG  = 0;
   localparam int OFS_ZERO = 1;
   localparam int OFS_POS  = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEN_X    = 2'd0,
      CSR_LEN_Y    = 2'd1,
      CSR_LEN_Z    = 2'd2,
      CSR_PERIODIC = 2'd3
   } csr_index_type;

   typedef logic [LEN_BITS-1:0]   len_type;
   typedef logic [NUM_OFS-1:0]    axis_hit_type;
   typedef logic [NUM_IMAGES-1:0] image_mask_type;

endpackage

@@ hw/rtl/periodic_image_overlap_finder.sv @@
// Top level of the periodic image overlap finder: registers and pipeline wiring.
//
// Usage:
//  - Command channel: a word (target box and source box corners) is taken at
//    a rising edge with start high and busy low.
//  - Result channel: rsp_valid marks each result word for exactly one cycle;
//    the receiver has no way to hold it off. Matching shifts come out in
//    x-outer, z-inner scan order, rsp_last flags the final word of a command,
//    and a command with no match gives one word with rsp_found low.
//  - Register channel: csr_ready is always high; index 0..2 set the domain
//    length along x/y/z, index 3 the periodic mask. Write only while idle.
// Path: the first result word passes the shift adders, comparators, mask fold,
//   emitter and output register, each of them registered.
// Flow: the emitter sends one word per cycle and takes the next mask in the
//   cycle it forms the current command's last word, so commands stream
//   back to back. busy rises only when the emitter backs up the pipeline.
// Reset: synchronous, clears all stage valids and sets lengths to 1 and
//   the periodic mask to 0.
module periodic_image_overlap_finder
   import pio_pkg::*;
#(
   parameter int DIMS       = 3,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   // command channel
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_target_lo_x,
   input  logic signed [COORD_BITS-1:0] req_target_lo_y,
   input  logic signed [COORD_BITS-1:0] req_target_lo_z,
   input  logic signed [COORD_BITS-1:0] req_target_hi_x,
   input  logic signed [COORD_BITS-1:0] req_target_hi_y,
   input  logic signed [COORD_BITS-1:0] req_target_hi_z,
   input  logic signed [COORD_BITS-1:0] req_src_lo_x,
   input  logic signed [COORD_BITS-1:0] req_src_lo_y,
   input  logic signed [COORD_BITS-1:0] req_src_lo_z,
   input  logic signed [COORD_BITS-1:0] req_src_hi_x,
   input  logic signed [COORD_BITS-1:0] req_src_hi_y,
   input  logic signed [COORD_BITS-1:0] req_src_hi_z,
   // result channel
   output logic                         rsp_valid,
   output logic signed [SHIFT_BITS-1:0] rsp_shift_x,
   output logic signed [SHIFT_BITS-1:0] rsp_shift_y,
   output logic signed [SHIFT_BITS-1:0] rsp_shift_z,
   output logic                         rsp_found,
   output logic                         rsp_last,
   // register write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [LEN_BITS-1:0]          csr_data
);

   // shifted corners need room for a full coordinate plus a signed length
   localparam int SUM_BITS = ((COORD_BITS > LEN_BITS + 1) ? COORD_BITS : LEN_BITS + 1) + 1;

   // ---------------- registers ----------------
   len_type             len_ff [NUM_AXES];
   logic [NUM_AXES-1:0] periodic_ff;
   logic                csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_AXES; d++) begin
            len_ff[d] <= len_type'(1);
         end
         periodic_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_LEN_X:    len_ff[0]   <= csr_data;
            CSR_LEN_Y:    len_ff[1]   <= csr_data;
            CSR_LEN_Z:    len_ff[2]   <= csr_data;
            CSR_PERIODIC: periodic_ff <= csr_data[NUM_AXES-1:0];
            default:      periodic_ff <= periodic_ff;
         endcase
      end
   end

   // ---------------- command fields as per-axis arrays ----------------
   logic signed [COORD_BITS-1:0] tlo [NUM_AXES];
   logic signed [COORD_BITS-1:0] thi [NUM_AXES];
   logic signed [COORD_BITS-1:0] slo [NUM_AXES];
   logic signed [COORD_BITS-1:0] shi [NUM_AXES];

   assign tlo[0] = req_target_lo_x;
   assign tlo[1] = req_target_lo_y;
   assign tlo[2] = req_target_lo_z;
   assign thi[0] = req_target_hi_x;
   assign thi[1] = req_target_hi_y;
   assign thi[2] = req_target_hi_z;
   assign slo[0] = req_src_lo_x;
   assign slo[1] = req_src_lo_y;
   assign slo[2] = req_src_lo_z;
   assign shi[0] = req_src_hi_x;
   assign shi[1] = req_src_hi_y;
   assign shi[2] = req_src_hi_z;

   // ---------------- pipeline ----------------
   logic s1_ready, s1_valid;
   logic s2_ready, s2_valid;
   logic s3_ready, s3_valid;
   logic em_ready;

   logic signed [SUM_BITS-1:0] s1_tlo     [NUM_AXES];
   logic signed [SUM_BITS-1:0] s1_thi     [NUM_AXES];
   logic signed [SUM_BITS-1:0] s1_slo     [NUM_AXES];
   logic signed [SUM_BITS-1:0] s1_shi     [NUM_AXES];
   logic signed [SUM_BITS-1:0] s1_slo_neg [NUM_AXES];
   logic signed [SUM_BITS-1:0] s1_slo_pos [NUM_AXES];
   logic signed [SUM_BITS-1:0] s1_shi_neg [NUM_AXES];
   logic signed [SUM_BITS-1:0] s1_shi_pos [NUM_AXES];
   axis_hit_type               s2_hit     [NUM_AXES];
   image_mask_type             s3_mask;

   // busy only when the first stage is full and cannot move on
   assign busy = !s1_ready;

   pio_shift_stage #(
      .COORD_BITS (COORD_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_shift (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start),
      .in_ready    (s1_ready),
      .tlo         (tlo),
      .thi         (thi),
      .slo         (slo),
      .shi         (shi),
      .len         (len_ff),
      .out_valid   (s1_valid),
      .out_ready   (s2_ready),
      .out_tlo     (s1_tlo),
      .out_thi     (s1_thi),
      .out_slo     (s1_slo),
      .out_shi     (s1_shi),
      .out_slo_neg (s1_slo_neg),
      .out_slo_pos (s1_slo_pos),
      .out_shi_neg (s1_shi_neg),
      .out_shi_pos (s1_shi_pos)
   );

   pio_compare_stage #(
      .DIMS     (DIMS),
      .SUM_BITS (SUM_BITS)
   ) u_compare (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .tlo       (s1_tlo),
      .thi       (s1_thi),
      .slo       (s1_slo),
      .shi       (s1_shi),
      .slo_neg   (s1_slo_neg),
      .slo_pos   (s1_slo_pos),
      .shi_neg   (s1_shi_neg),
      .shi_pos   (s1_shi_pos),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_hit   (s2_hit)
   );

   pio_mask_stage #(
      .DIMS (DIMS)
   ) u_mask (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s3_ready),
      .hit       (s2_hit),
      .periodic  (periodic_ff),
      .out_valid (s3_valid),
      .out_ready (em_ready),
      .out_mask  (s3_mask)
   );

   // lengths read live: user must change registers only while idle; not enforced
   pio_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid),
      .in_ready    (em_ready),
      .mask        (s3_mask),
      .len         (len_ff),
      .rsp_valid   (rsp_valid),
      .rsp_shift_x (rsp_shift_x),
      .rsp_shift_y (rsp_shift_y),
      .rsp_shift_z (rsp_shift_z),
      .rsp_found   (rsp_found),
      .rsp_last    (rsp_last)
   );

endmodule

@@ hw/rtl/pio_shift_stage.sv @@
// Stage 1: registers the boxes and forms the source corners shifted by +/- length.
module pio_shift_stage
   import pio_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int SUM_BITS   = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] tlo [NUM_AXES],
   input  logic signed [COORD_BITS-1:0] thi [NUM_AXES],
   input  logic signed [COORD_BITS-1:0] slo [NUM_AXES],
   input  logic signed [COORD_BITS-1:0] shi [NUM_AXES],
   input  len_type                      len [NUM_AXES],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [SUM_BITS-1:0]   out_tlo     [NUM_AXES],
   output logic signed [SUM_BITS-1:0]   out_thi     [NUM_AXES],
   output logic signed [SUM_BITS-1:0]   out_slo     [NUM_AXES],
   output logic signed [SUM_BITS-1:0]   out_shi     [NUM_AXES],
   output logic signed [SUM_BITS-1:0]   out_slo_neg [NUM_AXES],
   output logic signed [SUM_BITS-1:0]   out_slo_pos [NUM_AXES],
   output logic signed [SUM_BITS-1:0]   out_shi_neg [NUM_AXES],
   output logic signed [SUM_BITS-1:0]   out_shi_pos [NUM_AXES]
);

   logic                       valid_ff;
   logic signed [SUM_BITS-1:0] tlo_ff [NUM_AXES], tlo_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] thi_ff [NUM_AXES], thi_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] slo_ff [NUM_AXES], slo_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] shi_ff [NUM_AXES], shi_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] slo_neg_ff [NUM_AXES], slo_neg_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] slo_pos_ff [NUM_AXES], slo_pos_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] shi_neg_ff [NUM_AXES], shi_neg_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] shi_pos_ff [NUM_AXES], shi_pos_in [NUM_AXES];
   logic signed [SUM_BITS-1:0] len_ext [NUM_AXES];
   logic                       load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      for (int d = 0; d < NUM_AXES; d++) begin
         len_ext[d]    = $signed(SUM_BITS'(len[d]));
         tlo_in[d]     = SUM_BITS'(tlo[d]);
         thi_in[d]     = SUM_BITS'(thi[d]);
         slo_in[d]     = SUM_BITS'(slo[d]);
         shi_in[d]     = SUM_BITS'(shi[d]);
         slo_neg_in[d] = slo_in[d] - len_ext[d];
         slo_pos_in[d] = slo_in[d] + len_ext[d];
         shi_neg_in[d] = shi_in[d] - len_ext[d];
         shi_pos_in[d] = shi_in[d] + len_ext[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tlo_ff     <= tlo_in;
         thi_ff     <= thi_in;
         slo_ff     <= slo_in;
         shi_ff     <= shi_in;
         slo_neg_ff <= slo_neg_in;
         slo_pos_ff <= slo_pos_in;
         shi_neg_ff <= shi_neg_in;
         shi_pos_ff <= shi_pos_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_tlo     = tlo_ff;
   assign out_thi     = thi_ff;
   assign out_slo     = slo_ff;
   assign out_shi     = shi_ff;
   assign out_slo_neg = slo_neg_ff;
   assign out_slo_pos = slo_pos_ff;
   assign out_shi_neg = shi_neg_ff;
   assign out_shi_pos = shi_pos_ff;

endmodule

@@ hw/rtl/pio_compare_stage.sv @@
// Stage 2: per-axis overlap tests for the three offsets of each axis.
module pio_compare_stage
   import pio_pkg::*;
#(
   parameter int DIMS     = 3,
   parameter int SUM_BITS = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [SUM_BITS-1:0] tlo     [NUM_AXES],
   input  logic signed [SUM_BITS-1:0] thi     [NUM_AXES],
   input  logic signed [SUM_BITS-1:0] slo     [NUM_AXES],
   input  logic signed [SUM_BITS-1:0] shi     [NUM_AXES],
   input  logic signed [SUM_BITS-1:0] slo_neg [NUM_AXES],
   input  logic signed [SUM_BITS-1:0] slo_pos [NUM_AXES],
   input  logic signed [SUM_BITS-1:0] shi_neg [NUM_AXES],
   input  logic signed [SUM_BITS-1:0] shi_pos [NUM_AXES],
   output logic                       out_valid,
   input  logic                       out_ready,
   output axis_hit_type               out_hit [NUM_AXES]
);

   logic         valid_ff;
   axis_hit_type hit_ff [NUM_AXES];
   axis_hit_type hit_in [NUM_AXES];
   logic         nonempty [NUM_AXES];
   logic         load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // [slo+s, shi+s] meets [tlo, thi] when both boxes are nonempty and each
   // low corner sits at or below the other's high corner
   always_comb begin
      for (int d = 0; d < NUM_AXES; d++) begin
         nonempty[d] = (tlo[d] <= thi[d]) && (slo[d] <= shi[d]);
         hit_in[d][OFS_NEG]  = nonempty[d] && (tlo[d] <= shi_neg[d]) && (slo_neg[d] <= thi[d]);
         hit_in[d][OFS_ZERO] = nonempty[d] && (tlo[d] <= shi[d]) && (slo[d] <= thi[d]);
         hit_in[d][OFS_POS]  = nonempty[d] && (tlo[d] <= shi_pos[d]) && (slo_pos[d] <= thi[d]);
         if (d >= DIMS) begin
            hit_in[d] = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

endmodule

@@ hw/rtl/pio_mask_stage.sv @@
// Stage 3: folds per-axis hits and the periodic mask into one bit per image.
module pio_mask_stage
   import pio_pkg::*;
#(
   parameter int DIMS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  axis_hit_type        hit [NUM_AXES],
   input  logic [NUM_AXES-1:0] periodic,
   output logic                out_valid,
   input  logic                out_ready,
   output image_mask_type      out_mask
);

   logic           valid_ff;
   image_mask_type mask_ff;
   image_mask_type mask_in;
   logic           load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // image k = ox*9 + oy*3 + oz, so ascending bits follow x-outer scan order
   always_comb begin
      int   k;
      int   ofs [NUM_AXES];
      logic sel;
      k       = 0;
      mask_in = '0;
      for (int ox = 0; ox < NUM_OFS; ox++) begin
         for (int oy = 0; oy < NUM_OFS; oy++) begin
            for (int oz = 0; oz < NUM_OFS; oz++) begin
               ofs[0] = ox;
               ofs[1] = oy;
               ofs[2] = oz;
               sel    = (k != CENTER_IMAGE);
               for (int d = 0; d < NUM_AXES; d++) begin
                  if (ofs[d] != OFS_ZERO && (d >= DIMS || !periodic[d])) begin
                     sel = 1'b0;
                  end
                  sel = sel && hit[d][ofs[d]];
               end
               mask_in[k] = sel;
               k = k + 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mask_ff <= mask_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mask  = mask_ff;

endmodule

@@ hw/rtl/pio_emitter.sv @@
// Result emitter: drains one image mask, one matching shift per cycle.
module pio_emitter
   import pio_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  image_mask_type               mask,
   input  len_type                      len [NUM_AXES],
   output logic                         rsp_valid,
   output logic signed [SHIFT_BITS-1:0] rsp_shift_x,
   output logic signed [SHIFT_BITS-1:0] rsp_shift_y,
   output logic signed [SHIFT_BITS-1:0] rsp_shift_z,
   output logic                         rsp_found,
   output logic                         rsp_last
);

   logic                         em_valid_ff;
   image_mask_type               em_mask_ff;
   image_mask_type               em_mask_in;
   image_mask_type               mask_dec;
   image_mask_type               low_bit;
   image_mask_type               rest;
   logic                         done;
   logic                         load;
   logic [NUM_AXES-1:0]          neg;
   logic [NUM_AXES-1:0]          pos;
   logic signed [SHIFT_BITS-1:0] shift_in [NUM_AXES];
   logic signed [SHIFT_BITS-1:0] shift_ff [NUM_AXES];
   logic                         rsp_valid_ff;
   logic                         found_ff;
   logic                         last_ff;

   assign mask_dec = em_mask_ff - image_mask_type'(1);
   assign low_bit  = em_mask_ff & ~mask_dec;
   assign rest     = em_mask_ff & mask_dec;
   // an empty mask is also done on its first word: the no-match word
   assign done     = em_valid_ff && (rest == '0);
   assign in_ready = !em_valid_ff || done;
   assign load     = in_valid && in_ready;

   always_comb begin
      int k;
      k   = 0;
      neg = '0;
      pos = '0;
      for (int ox = 0; ox < NUM_OFS; ox++) begin
         for (int oy = 0; oy < NUM_OFS; oy++) begin
            for (int oz = 0; oz < NUM_OFS; oz++) begin
               if (low_bit[k]) begin
                  neg[0] = neg[0] | (ox == OFS_NEG);
                  pos[0] = pos[0] | (ox == OFS_POS);
                  neg[1] = neg[1] | (oy == OFS_NEG);
                  pos[1] = pos[1] | (oy == OFS_POS);
                  neg[2] = neg[2] | (oz == OFS_NEG);
                  pos[2] = pos[2] | (oz == OFS_POS);
               end
               k = k + 1;
            end
         end
      end
      for (int d = 0; d < NUM_AXES; d++) begin
         if (neg[d]) begin
            shift_in[d] = -$signed(SHIFT_BITS'(len[d]));
         end else if (pos[d]) begin
            shift_in[d] = $signed(SHIFT_BITS'(len[d]));
         end else begin
            shift_in[d] = '0;
         end
      end
   end

   always_comb begin
      if (load) begin
         em_mask_in = mask;
      end else begin
         em_mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= em_valid_ff;
         if (load) begin
            em_valid_ff <= 1'b1;
         end else if (done) begin
            em_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      em_mask_ff <= em_mask_in;
      if (em_valid_ff) begin
         shift_ff <= shift_in;
         found_ff <= (em_mask_ff != '0);
         last_ff  <= (rest == '0);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_shift_x = shift_ff[0];
   assign rsp_shift_y = shift_ff[1];
   assign rsp_shift_z = shift_ff[2];
   assign rsp_found   = found_ff;
   assign rsp_last    = last_ff;

endmodule
